[rtl/core/wetpc_pkg.sv]
// Shared types, codes and defaults for the weighted edge table path cost block.
// No dependencies; imported by wetpc_ctrl and the top level of the block.
`default_nettype none

package wetpc_pkg;

  // Default sizing
  localparam int MAX_EDGES_DEF    = 32;
  localparam int MAX_VERTICES_DEF = 64;
  localparam int VERTEX_BITS_DEF  = 8;
  localparam int WEIGHT_BITS_DEF  = 16;
  localparam int COST_BITS        = 32;

  // Request opcodes
  localparam logic [1:0] OP_ADD  = 2'd0;
  localparam logic [1:0] OP_LIST = 2'd1;
  localparam logic [1:0] OP_PATH = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_ADD  = 2'd0;
  localparam logic [1:0] KIND_NBR  = 2'd1;
  localparam logic [1:0] KIND_PATH = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_ADD_UPDATED  = 2'd0;
  localparam logic [1:0] ST_ADD_INSERTED = 2'd1;
  localparam logic [1:0] ST_ADD_FULL     = 2'd2;
  localparam logic [1:0] ST_PATH_OK      = 2'd0;
  localparam logic [1:0] ST_PATH_MISSING = 2'd1;
  localparam logic [1:0] ST_NONE         = 2'd0;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_E_SCAN,
    S_V_SCAN,
    S_A_DEC,
    S_A_VB,
    S_P_ADD,
    S_L_VREAD,
    S_L_VWAIT,
    S_L_PUSH,
    S_L_END,
    S_EMIT
  } state_t;

  // Result item without the vertex field
  typedef struct packed {
    logic [1:0]           kind;
    logic [1:0]           status;
    logic                 nb_valid;
    logic [COST_BITS-1:0] cost;
    logic                 last;
  } res_t;

  // Sequencer to output register
  typedef struct packed {
    logic load;
    res_t item;
  } out_ctl_t;

endpackage

`default_nettype wire

[rtl/core/wetpc_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module wetpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/core/wetpc_ctrl.sv]
// Sequencer and shared compare/add unit that scans the edge and vertex tables.
// Depends on wetpc_pkg; drives the ports of the two table RAMs.
`default_nettype none

module wetpc_ctrl
  import wetpc_pkg::*;
#(
  parameter int MAX_EDGES    = MAX_EDGES_DEF,
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int VERTEX_BITS  = VERTEX_BITS_DEF,
  parameter int WEIGHT_BITS  = WEIGHT_BITS_DEF,
  localparam int EA = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1,
  localparam int EC = $clog2(MAX_EDGES + 1),
  localparam int VA = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1,
  localparam int VC = $clog2(MAX_VERTICES + 1),
  localparam int EW = 2 * VERTEX_BITS + WEIGHT_BITS
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // Request channel
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [1:0]             in_op,
  input  wire logic [VERTEX_BITS-1:0] in_vertex_a,
  input  wire logic [VERTEX_BITS-1:0] in_vertex_b,
  input  wire logic [WEIGHT_BITS-1:0] in_weight,
  input  wire logic                   in_path_first,
  input  wire logic                   in_path_last,
  // Output register side
  input  wire logic                   out_free,
  output out_ctl_t                    out_ctl,
  output logic [VERTEX_BITS-1:0]      out_nb,
  // Edge table RAM
  output logic                        e_we,
  output logic [EA-1:0]               e_waddr,
  output logic [EW-1:0]               e_wdata,
  output logic [EA-1:0]               e_raddr,
  input  wire logic [EW-1:0]          e_rdata,
  // Vertex list RAM
  output logic                        v_we,
  output logic [VA-1:0]               v_waddr,
  output logic [VERTEX_BITS-1:0]      v_wdata,
  output logic [VA-1:0]               v_raddr,
  input  wire logic [VERTEX_BITS-1:0] v_rdata
);

  state_t                 state_r, state_nxt;
  logic [1:0]             op_r, op_nxt;
  logic [VERTEX_BITS-1:0] a_r, a_nxt;
  logic [VERTEX_BITS-1:0] b_r, b_nxt;
  logic [WEIGHT_BITS-1:0] w_r, w_nxt;
  logic                   last_r, last_nxt;
  logic [WEIGHT_BITS-1:0] wgt_r, wgt_nxt;
  logic [EC-1:0]          ei_r, ei_nxt;
  logic [EA-1:0]          eidx_r, eidx_nxt;
  logic                   cmp_v_r, cmp_v_nxt;
  logic [VC-1:0]          vi_r, vi_nxt;
  logic [EC-1:0]          ecount_r, ecount_nxt;
  logic [VC-1:0]          vcount_r, vcount_nxt;
  logic [VERTEX_BITS-1:0] key_s_r, key_s_nxt;
  logic [VERTEX_BITS-1:0] key_d_r, key_d_nxt;
  logic                   seen_a_r, seen_a_nxt;
  logic                   seen_b_r, seen_b_nxt;
  logic                   pend_v_r, pend_v_nxt;
  logic [VERTEX_BITS-1:0] pend_nb_r, pend_nb_nxt;
  logic [VERTEX_BITS-1:0] prev_r, prev_nxt;
  logic [COST_BITS-1:0]   cost_r, cost_nxt;
  logic                   broken_r, broken_nxt;
  res_t                   res_r, res_nxt;

  logic [VERTEX_BITS-1:0] rd_src, rd_dst;
  logic [WEIGHT_BITS-1:0] rd_w;
  logic                   e_match;
  logic                   new_a, new_b;
  logic [VC:0]            v_need_sum;
  logic [COST_BITS:0]     cost_sum;
  logic [COST_BITS-1:0]   cost_sat;

  // Split the edge entry and compare it against the search key
  assign rd_src  = e_rdata[EW-1 -: VERTEX_BITS];
  assign rd_dst  = e_rdata[WEIGHT_BITS +: VERTEX_BITS];
  assign rd_w    = e_rdata[WEIGHT_BITS-1:0];
  assign e_match = cmp_v_r && (rd_src == key_s_r) && (rd_dst == key_d_r);

  // Insert decision terms
  assign new_a      = !seen_a_r;
  assign new_b      = (b_r != a_r) && !seen_b_r;
  assign v_need_sum = {1'b0, vcount_r} + (VC + 1)'(new_a) + (VC + 1)'(new_b);

  // Saturating path accumulation
  assign cost_sum = {1'b0, cost_r} + (COST_BITS + 1)'(wgt_r);
  assign cost_sat = cost_sum[COST_BITS] ? {COST_BITS{1'b1}} : cost_sum[COST_BITS-1:0];

  // Tables are always read at the scan pointers
  assign e_raddr  = ei_r[EA-1:0];
  assign v_raddr  = vi_r[VA-1:0];
  assign in_stall = (state_r != S_IDLE);

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ecount_r <= '0;
      vcount_r <= '0;
      prev_r   <= '0;
      cost_r   <= '0;
      broken_r <= 1'b0;
      cmp_v_r  <= 1'b0;
      pend_v_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ecount_r <= ecount_nxt;
      vcount_r <= vcount_nxt;
      prev_r   <= prev_nxt;
      cost_r   <= cost_nxt;
      broken_r <= broken_nxt;
      cmp_v_r  <= cmp_v_nxt;
      pend_v_r <= pend_v_nxt;
    end
  end

  // Payload and pointer registers
  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    w_r       <= w_nxt;
    last_r    <= last_nxt;
    wgt_r     <= wgt_nxt;
    ei_r      <= ei_nxt;
    eidx_r    <= eidx_nxt;
    vi_r      <= vi_nxt;
    key_s_r   <= key_s_nxt;
    key_d_r   <= key_d_nxt;
    seen_a_r  <= seen_a_nxt;
    seen_b_r  <= seen_b_nxt;
    pend_nb_r <= pend_nb_nxt;
    res_r     <= res_nxt;
  end

  // Next state and outputs
  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    a_nxt       = a_r;
    b_nxt       = b_r;
    w_nxt       = w_r;
    last_nxt    = last_r;
    wgt_nxt     = wgt_r;
    ei_nxt      = ei_r;
    eidx_nxt    = eidx_r;
    cmp_v_nxt   = cmp_v_r;
    vi_nxt      = vi_r;
    ecount_nxt  = ecount_r;
    vcount_nxt  = vcount_r;
    key_s_nxt   = key_s_r;
    key_d_nxt   = key_d_r;
    seen_a_nxt  = seen_a_r;
    seen_b_nxt  = seen_b_r;
    pend_v_nxt  = pend_v_r;
    pend_nb_nxt = pend_nb_r;
    prev_nxt    = prev_r;
    cost_nxt    = cost_r;
    broken_nxt  = broken_r;
    res_nxt     = res_r;
    e_we        = 1'b0;
    e_waddr     = eidx_r;
    e_wdata     = {a_r, b_r, w_r};
    v_we        = 1'b0;
    v_waddr     = vcount_r[VA-1:0];
    v_wdata     = a_r;
    out_ctl     = '{load: 1'b0, item: res_r};
    out_nb      = '0;

    unique case (state_r)
      // Take a request and start its first pass, if it needs one
      S_IDLE: begin
        if (in_valid) begin
          op_nxt   = in_op;
          a_nxt    = in_vertex_a;
          b_nxt    = in_vertex_b;
          w_nxt    = in_weight;
          last_nxt = in_path_last;
          unique case (in_op)
            OP_ADD: begin
              key_s_nxt = in_vertex_a;
              key_d_nxt = in_vertex_b;
              ei_nxt    = '0;
              cmp_v_nxt = 1'b0;
              state_nxt = S_E_SCAN;
            end
            OP_LIST: begin
              vi_nxt     = '0;
              pend_v_nxt = 1'b0;
              state_nxt  = S_L_VREAD;
            end
            OP_PATH: begin
              priority if (in_path_first) begin
                cost_nxt   = '0;
                broken_nxt = 1'b0;
                prev_nxt   = in_vertex_a;
                if (in_path_last) begin
                  res_nxt   = '{kind: KIND_PATH, status: ST_PATH_OK, nb_valid: 1'b0,
                                cost: '0, last: 1'b1};
                  state_nxt = S_EMIT;
                end
              end else if (broken_r) begin
                prev_nxt = in_vertex_a;
                if (in_path_last) begin
                  res_nxt   = '{kind: KIND_PATH, status: ST_PATH_MISSING, nb_valid: 1'b0,
                                cost: '0, last: 1'b1};
                  state_nxt = S_EMIT;
                end
              end else begin
                key_s_nxt = prev_r;
                key_d_nxt = in_vertex_a;
                ei_nxt    = '0;
                cmp_v_nxt = 1'b0;
                state_nxt = S_E_SCAN;
              end
            end
            default: begin
              // unused opcode: drop
            end
          endcase
        end
      end

      // Walk the edge table one entry a cycle, first match wins
      S_E_SCAN: begin
        priority if (e_match) begin
          cmp_v_nxt = 1'b0;
          unique case (op_r)
            OP_ADD: begin
              e_we      = 1'b1;
              res_nxt   = '{kind: KIND_ADD, status: ST_ADD_UPDATED, nb_valid: 1'b0,
                            cost: '0, last: 1'b1};
              state_nxt = S_EMIT;
            end
            OP_PATH: begin
              wgt_nxt   = rd_w;
              state_nxt = S_P_ADD;
            end
            OP_LIST: begin
              if (pend_v_r) begin
                state_nxt = S_L_PUSH;
              end else begin
                pend_v_nxt  = 1'b1;
                pend_nb_nxt = key_d_r;
                vi_nxt      = vi_r + 1'b1;
                state_nxt   = S_L_VREAD;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end else if (ei_r == ecount_r) begin
          cmp_v_nxt = 1'b0;
          unique case (op_r)
            OP_ADD: begin
              vi_nxt     = '0;
              seen_a_nxt = 1'b0;
              seen_b_nxt = 1'b0;
              state_nxt  = S_V_SCAN;
            end
            OP_PATH: begin
              broken_nxt = 1'b1;
              cost_nxt   = '0;
              prev_nxt   = a_r;
              if (last_r) begin
                res_nxt   = '{kind: KIND_PATH, status: ST_PATH_MISSING, nb_valid: 1'b0,
                              cost: '0, last: 1'b1};
                state_nxt = S_EMIT;
              end else begin
                state_nxt = S_IDLE;
              end
            end
            OP_LIST: begin
              vi_nxt    = vi_r + 1'b1;
              state_nxt = S_L_VREAD;
            end
            default: state_nxt = S_IDLE;
          endcase
        end else begin
          cmp_v_nxt = 1'b1;
          eidx_nxt  = ei_r[EA-1:0];
          ei_nxt    = ei_r + 1'b1;
        end
      end

      // Look up both endpoints in the vertex list
      S_V_SCAN: begin
        if (cmp_v_r && (v_rdata == a_r)) begin
          seen_a_nxt = 1'b1;
        end
        if (cmp_v_r && (v_rdata == b_r)) begin
          seen_b_nxt = 1'b1;
        end
        if (vi_r == vcount_r) begin
          cmp_v_nxt = 1'b0;
          state_nxt = S_A_DEC;
        end else begin
          cmp_v_nxt = 1'b1;
          vi_nxt    = vi_r + 1'b1;
        end
      end

      // Insert the edge and its new vertices, or report full
      S_A_DEC: begin
        if ((ecount_r == EC'(MAX_EDGES)) || (v_need_sum > (VC + 1)'(MAX_VERTICES))) begin
          res_nxt   = '{kind: KIND_ADD, status: ST_ADD_FULL, nb_valid: 1'b0,
                        cost: '0, last: 1'b1};
          state_nxt = S_EMIT;
        end else begin
          e_we       = 1'b1;
          e_waddr    = ecount_r[EA-1:0];
          ecount_nxt = ecount_r + 1'b1;
          res_nxt    = '{kind: KIND_ADD, status: ST_ADD_INSERTED, nb_valid: 1'b0,
                         cost: '0, last: 1'b1};
          state_nxt  = S_EMIT;
          if (new_a || new_b) begin
            v_we       = 1'b1;
            v_wdata    = new_a ? a_r : b_r;
            vcount_nxt = vcount_r + 1'b1;
          end
          if (new_a && new_b) begin
            state_nxt = S_A_VB;
          end
        end
      end

      // Second vertex write of an insert
      S_A_VB: begin
        v_we       = 1'b1;
        v_wdata    = b_r;
        vcount_nxt = vcount_r + 1'b1;
        state_nxt  = S_EMIT;
      end

      // Accumulate the matched edge weight
      S_P_ADD: begin
        cost_nxt = cost_sat;
        prev_nxt = a_r;
        if (last_r) begin
          res_nxt   = '{kind: KIND_PATH, status: ST_PATH_OK, nb_valid: 1'b0,
                        cost: cost_sat, last: 1'b1};
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_IDLE;
        end
      end

      // Fetch the next candidate neighbor
      S_L_VREAD: begin
        state_nxt = (vi_r == vcount_r) ? S_L_END : S_L_VWAIT;
      end

      S_L_VWAIT: begin
        key_s_nxt = a_r;
        key_d_nxt = v_rdata;
        ei_nxt    = '0;
        cmp_v_nxt = 1'b0;
        state_nxt = S_E_SCAN;
      end

      // Send the held neighbor, keep the new one back
      S_L_PUSH: begin
        if (out_free) begin
          out_ctl.load = 1'b1;
          out_ctl.item = '{kind: KIND_NBR, status: ST_NONE, nb_valid: 1'b1,
                           cost: '0, last: 1'b0};
          out_nb       = pend_nb_r;
          pend_nb_nxt  = key_d_r;
          vi_nxt       = vi_r + 1'b1;
          state_nxt    = S_L_VREAD;
        end
      end

      // Close the list: held neighbor as final, or one empty item
      S_L_END: begin
        if (out_free) begin
          out_ctl.load = 1'b1;
          out_ctl.item = '{kind: KIND_NBR, status: ST_NONE, nb_valid: pend_v_r,
                           cost: '0, last: 1'b1};
          out_nb       = pend_v_r ? pend_nb_r : '0;
          pend_v_nxt   = 1'b0;
          state_nxt    = S_IDLE;
        end
      end

      // Hand a single result to the output register
      S_EMIT: begin
        if (out_free) begin
          out_ctl.load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Table fill never passes its depth
  a_ecount_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ecount_r <= EC'(MAX_EDGES))
    else $error("edge count beyond table depth");

  a_vcount_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vcount_r <= VC'(MAX_VERTICES))
    else $error("vertex count beyond list depth");

  // A result is only loaded when the output register can take it
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_ctl.load |-> out_free)
    else $error("result loaded into a busy output register");

  // Second vertex write always follows the insert decision
  a_vb_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_A_VB) |-> ($past(state_r) == S_A_DEC))
    else $error("second vertex write out of sequence");

  // An insert grows the edge count by exactly one
  a_insert_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_A_DEC && e_we) |=> (ecount_r == $past(ecount_r) + 1'b1))
    else $error("edge count did not advance on insert");

endmodule

`default_nettype wire

[rtl/core/weighted_edge_table_path_cost.sv]
// Top level: edge and vertex table RAMs, sequencer and result output register.
// Depends on wetpc_pkg, wetpc_ram and wetpc_ctrl.
`default_nettype none

// Directed weighted edge table with neighbor listing and path cost. One request
// is worked at a time; in_stall stays high until the request's last result has
// been handed to the output register, which lets the next request in while a
// result still waits on out_stall. One compare unit walks the edge table (E
// entries in use) and the vertex list (V entries in use) one entry per cycle
// through registered-read RAMs. An update of an existing edge scans the edge
// table, an insert or full answer scans the edge table and then the vertex list,
// a path vertex scans the edge table, and a neighbor listing scans the edge table
// once per listed vertex. No clearing pass follows reset: the tables are only read
// below their fill counts, which reset clears.
module weighted_edge_table_path_cost
  import wetpc_pkg::*;
#(
  parameter int MAX_EDGES    = MAX_EDGES_DEF,
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int VERTEX_BITS  = VERTEX_BITS_DEF,
  parameter int WEIGHT_BITS  = WEIGHT_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // Request channel
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [1:0]             in_op,
  input  wire logic [VERTEX_BITS-1:0] in_vertex_a,
  input  wire logic [VERTEX_BITS-1:0] in_vertex_b,
  input  wire logic [WEIGHT_BITS-1:0] in_weight,
  input  wire logic                   in_path_first,
  input  wire logic                   in_path_last,
  // Result channel
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [1:0]                  out_kind,
  output logic [1:0]                  out_status,
  output logic [VERTEX_BITS-1:0]      out_neighbor,
  output logic                        out_neighbor_valid,
  output logic [COST_BITS-1:0]        out_cost,
  output logic                        out_last
);

  localparam int EA = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int VA = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int EW = 2 * VERTEX_BITS + WEIGHT_BITS;

  logic                   e_we, v_we;
  logic [EA-1:0]          e_waddr, e_raddr;
  logic [EW-1:0]          e_wdata, e_rdata;
  logic [VA-1:0]          v_waddr, v_raddr;
  logic [VERTEX_BITS-1:0] v_wdata, v_rdata;
  out_ctl_t               out_ctl;
  logic [VERTEX_BITS-1:0] ctl_nb;
  logic                   out_free;

  logic                   out_valid_r;
  res_t                   out_item_r;
  logic [VERTEX_BITS-1:0] out_nb_r;

  wetpc_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk   (clk),
    .we    (e_we),
    .waddr (e_waddr),
    .wdata (e_wdata),
    .raddr (e_raddr),
    .rdata (e_rdata)
  );

  wetpc_ram #(.WIDTH(VERTEX_BITS), .DEPTH(MAX_VERTICES)) u_vertex_ram (
    .clk   (clk),
    .we    (v_we),
    .waddr (v_waddr),
    .wdata (v_wdata),
    .raddr (v_raddr),
    .rdata (v_rdata)
  );

  wetpc_ctrl #(
    .MAX_EDGES    (MAX_EDGES),
    .MAX_VERTICES (MAX_VERTICES),
    .VERTEX_BITS  (VERTEX_BITS),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_op         (in_op),
    .in_vertex_a   (in_vertex_a),
    .in_vertex_b   (in_vertex_b),
    .in_weight     (in_weight),
    .in_path_first (in_path_first),
    .in_path_last  (in_path_last),
    .out_free      (out_free),
    .out_ctl       (out_ctl),
    .out_nb        (ctl_nb),
    .e_we          (e_we),
    .e_waddr       (e_waddr),
    .e_wdata       (e_wdata),
    .e_raddr       (e_raddr),
    .e_rdata       (e_rdata),
    .v_we          (v_we),
    .v_waddr       (v_waddr),
    .v_wdata       (v_wdata),
    .v_raddr       (v_raddr),
    .v_rdata       (v_rdata)
  );

  // Output register frees up when empty or on a transfer
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ctl.load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Hold the payload until its transfer
  always_ff @(posedge clk) begin
    if (out_ctl.load) begin
      out_item_r <= out_ctl.item;
      out_nb_r   <= ctl_nb;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_kind           = out_item_r.kind;
  assign out_status         = out_item_r.status;
  assign out_neighbor       = out_nb_r;
  assign out_neighbor_valid = out_item_r.nb_valid;
  assign out_cost           = out_item_r.cost;
  assign out_last           = out_item_r.last;

endmodule

`default_nettype wire

[tb/sv/tb.sv]
// Testbench for weighted_edge_table_path_cost: directed and random add, neighbor
// listing and path requests, checked against a scoreboard that tracks the edge table.
// Depends on wetpc_pkg and the weighted_edge_table_path_cost RTL.

import wetpc_pkg::*;

typedef struct {
  logic [1:0]                 kind;
  logic [1:0]                 status;
  logic [VERTEX_BITS_DEF-1:0] neighbor;
  logic                       nb_valid;
  logic [COST_BITS-1:0]       cost;
  logic                       last;
} graph_result_t;

class graph_scoreboard;
  bit [VERTEX_BITS_DEF-1:0] src_tab[MAX_EDGES_DEF];
  bit [VERTEX_BITS_DEF-1:0] dst_tab[MAX_EDGES_DEF];
  bit [WEIGHT_BITS_DEF-1:0] wt_tab[MAX_EDGES_DEF];
  bit [VERTEX_BITS_DEF-1:0] vtx_list[MAX_VERTICES_DEF];
  int                       n_edges;
  int                       n_vertices;
  bit [VERTEX_BITS_DEF-1:0] prev_vertex;
  bit [COST_BITS-1:0]       path_cost;
  bit                       path_broken;
  graph_result_t            pending_results[$];
  int                       errors;

  function new();
    n_edges     = 0;
    n_vertices  = 0;
    prev_vertex = '0;
    path_cost   = '0;
    path_broken = 1'b0;
    errors      = 0;
  endfunction

  function int find_link(bit [VERTEX_BITS_DEF-1:0] s, bit [VERTEX_BITS_DEF-1:0] d);
    for (int i = 0; i < n_edges; i++) begin
      if (src_tab[i] == s && dst_tab[i] == d) return i;
    end
    return -1;
  endfunction

  function bit vertex_known(bit [VERTEX_BITS_DEF-1:0] v);
    for (int i = 0; i < n_vertices; i++) begin
      if (vtx_list[i] == v) return 1'b1;
    end
    return 1'b0;
  endfunction

  function void push_result(logic [1:0] kind, logic [1:0] status,
                            logic [VERTEX_BITS_DEF-1:0] nb, logic nb_valid,
                            logic [COST_BITS-1:0] cost, logic last);
    graph_result_t r;
    r.kind     = kind;
    r.status   = status;
    r.neighbor = nb;
    r.nb_valid = nb_valid;
    r.cost     = cost;
    r.last     = last;
    pending_results = {pending_results, r};
  endfunction

  // Update the table copy for one accepted request and queue its results
  function void record_request(logic [1:0] op, logic [VERTEX_BITS_DEF-1:0] va,
                               logic [VERTEX_BITS_DEF-1:0] vb,
                               logic [WEIGHT_BITS_DEF-1:0] w,
                               logic first, logic lastm);
    int              idx;
    bit              new_a;
    bit              new_b;
    int              need;
    int              hits;
    int              seen;
    bit [COST_BITS:0] sum;
    case (op)
      OP_ADD: begin
        idx = find_link(va, vb);
        if (idx >= 0) begin
          wt_tab[idx] = w;
          push_result(KIND_ADD, ST_ADD_UPDATED, '0, 1'b0, '0, 1'b1);
        end else begin
          new_a = !vertex_known(va);
          new_b = (vb != va) && !vertex_known(vb);
          need  = new_a + new_b;
          if (n_edges >= MAX_EDGES_DEF || n_vertices + need > MAX_VERTICES_DEF) begin
            push_result(KIND_ADD, ST_ADD_FULL, '0, 1'b0, '0, 1'b1);
          end else begin
            src_tab[n_edges] = va;
            dst_tab[n_edges] = vb;
            wt_tab[n_edges]  = w;
            n_edges++;
            if (new_a) begin
              vtx_list[n_vertices] = va;
              n_vertices++;
            end
            if (new_b) begin
              vtx_list[n_vertices] = vb;
              n_vertices++;
            end
            push_result(KIND_ADD, ST_ADD_INSERTED, '0, 1'b0, '0, 1'b1);
          end
        end
      end
      OP_LIST: begin
        // Count first so the final neighbor carries the last flag
        hits = 0;
        for (int i = 0; i < n_vertices; i++) begin
          if (find_link(va, vtx_list[i]) >= 0) hits++;
        end
        if (hits == 0) begin
          push_result(KIND_NBR, ST_NONE, '0, 1'b0, '0, 1'b1);
        end else begin
          seen = 0;
          for (int i = 0; i < n_vertices; i++) begin
            if (find_link(va, vtx_list[i]) >= 0) begin
              seen++;
              push_result(KIND_NBR, ST_NONE, vtx_list[i], 1'b1, '0, seen == hits);
            end
          end
        end
      end
      OP_PATH: begin
        if (first) begin
          path_cost   = '0;
          path_broken = 1'b0;
        end else if (!path_broken) begin
          idx = find_link(prev_vertex, va);
          if (idx < 0) begin
            path_broken = 1'b1;
            path_cost   = '0;
          end else begin
            sum       = path_cost + wt_tab[idx];
            path_cost = sum[COST_BITS] ? '1 : sum[COST_BITS-1:0];
          end
        end
        prev_vertex = va;
        if (lastm) begin
          if (path_broken) push_result(KIND_PATH, ST_PATH_MISSING, '0, 1'b0, '0, 1'b1);
          else push_result(KIND_PATH, ST_PATH_OK, '0, 1'b0, path_cost, 1'b1);
        end
      end
      default: ;
    endcase
  endfunction

  function void compare_field(string name, logic [COST_BITS-1:0] want,
                              logic [COST_BITS-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  // Compare one result transfer with the oldest queued result
  function void check_result(graph_result_t got);
    graph_result_t want;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected result: expected none, actual kind %0h status %0h",
               $time, got.kind, got.status);
      errors++;
      return;
    end
    want = pending_results.pop_front();
    compare_field("kind", want.kind, got.kind);
    compare_field("status", want.status, got.status);
    compare_field("neighbor", want.neighbor, got.neighbor);
    compare_field("neighbor_valid", want.nb_valid, got.nb_valid);
    compare_field("cost", want.cost, got.cost);
    compare_field("last", want.last, got.last);
  endfunction
endclass

module tb;
  localparam int         VB             = VERTEX_BITS_DEF;
  localparam int         WB             = WEIGHT_BITS_DEF;
  localparam int         WATCHDOG_LIMIT = 20000;
  localparam int         ITEM_TARGET    = 280;
  localparam logic [1:0] OP_UNUSED      = 2'd3;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [1:0]           in_op;
  logic [VB-1:0]        in_vertex_a;
  logic [VB-1:0]        in_vertex_b;
  logic [WB-1:0]        in_weight;
  logic                 in_path_first;
  logic                 in_path_last;
  logic                 out_valid;
  logic                 out_stall;
  logic [1:0]           out_kind;
  logic [1:0]           out_status;
  logic [VB-1:0]        out_neighbor;
  logic                 out_neighbor_valid;
  logic [COST_BITS-1:0] out_cost;
  logic                 out_last;

  graph_scoreboard sb;
  graph_result_t   seen_result;
  int              items_sent;
  int              next_drain;
  int              idle_cycles = 0;
  bit              quiet;
  logic [VB-1:0]   hubs[12];

  weighted_edge_table_path_cost i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_op              (in_op),
    .in_vertex_a        (in_vertex_a),
    .in_vertex_b        (in_vertex_b),
    .in_weight          (in_weight),
    .in_path_first      (in_path_first),
    .in_path_last       (in_path_last),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_status         (out_status),
    .out_neighbor       (out_neighbor),
    .out_neighbor_valid (out_neighbor_valid),
    .out_cost           (out_cost),
    .out_last           (out_last)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Stall the result channel at random, except in the quiet stretch
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall = !quiet && ($urandom_range(99) < 13);
    end
  end

  // Check each result transfer
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen_result.kind     = out_kind;
      seen_result.status   = out_status;
      seen_result.neighbor = out_neighbor;
      seen_result.nb_valid = out_neighbor_valid;
      seen_result.cost     = out_cost;
      seen_result.last     = out_last;
      sb.check_result(seen_result);
    end
  end

  // Abort when no transfer happens for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Drive one request, starting and ending at a falling edge
  task automatic send_request(input logic [1:0] op, input logic [VB-1:0] va,
                              input logic [VB-1:0] vb, input logic [WB-1:0] w,
                              input logic first, input logic lastm);
    while (!quiet && $urandom_range(99) < 13) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid      = 1'b1;
    in_op         = op;
    in_vertex_a   = va;
    in_vertex_b   = vb;
    in_weight     = w;
    in_path_first = first;
    in_path_last  = lastm;
    do @(posedge clk); while (in_stall);
    sb.record_request(op, va, vb, w, first, lastm);
    if (op != OP_UNUSED) items_sent++;
    @(negedge clk);
  endtask

  // Hold the request channel until every queued result has arrived
  task automatic wait_results_drained();
    in_valid = 1'b0;
    while (sb.pending_results.size() != 0) @(negedge clk);
  endtask

  function automatic logic [VB-1:0] pick_vertex();
    if ($urandom_range(99) < 85) return hubs[$urandom_range(11)];
    return VB'($urandom_range(255));
  endfunction

  // Send a path, mostly along existing edges, sometimes broken or without a start mark
  task automatic send_path();
    int            len;
    int            outs[$];
    bit            fresh;
    logic [VB-1:0] cur;
    logic [VB-1:0] nxt;
    len   = $urandom_range(1, 6);
    fresh = ($urandom_range(99) >= 10);
    if (sb.n_edges > 0 && $urandom_range(99) < 80) cur = sb.src_tab[$urandom_range(sb.n_edges - 1)];
    else cur = pick_vertex();
    send_request(OP_PATH, cur, VB'($urandom), WB'($urandom), fresh, len == 1);
    for (int k = 1; k < len; k++) begin
      outs.delete();
      for (int i = 0; i < sb.n_edges; i++) begin
        if (sb.src_tab[i] == cur) outs = {outs, i};
      end
      if (outs.size() > 0 && $urandom_range(99) < 85) nxt = sb.dst_tab[outs[$urandom_range(outs.size() - 1)]];
      else nxt = pick_vertex();
      send_request(OP_PATH, nxt, VB'($urandom), WB'($urandom), 1'b0, k == len - 1);
      cur = nxt;
    end
  endtask

  initial begin
    int r;
    sb            = new();
    quiet         = 1'b0;
    items_sent    = 0;
    next_drain    = 70;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_op         = OP_ADD;
    in_vertex_a   = '0;
    in_vertex_b   = '0;
    in_weight     = '0;
    in_path_first = 1'b0;
    in_path_last  = 1'b0;
    foreach (hubs[i]) hubs[i] = VB'($urandom_range(255));
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty table, path without start mark, single-vertex path
    send_request(OP_LIST, 8'h00, 8'hFF, 16'hFFFF, 1'b1, 1'b1);
    send_request(OP_PATH, 8'h00, 8'h00, 16'h0000, 1'b0, 1'b1);
    send_request(OP_PATH, 8'hFF, 8'hFF, 16'hFFFF, 1'b1, 1'b1);
    // Inserts, an update and a self loop
    send_request(OP_ADD, 8'h00, 8'hFF, 16'hFFFF, 1'b0, 1'b0);
    send_request(OP_ADD, 8'hFF, 8'h00, 16'h0000, 1'b1, 1'b1);
    send_request(OP_ADD, 8'h00, 8'hFF, 16'h1234, 1'b0, 1'b1);
    send_request(OP_ADD, 8'hFF, 8'hFF, 16'hFFFF, 1'b1, 1'b0);
    send_request(OP_ADD, 8'h00, 8'h80, 16'h0001, 1'b0, 1'b0);
    send_request(OP_ADD, 8'h7F, 8'h01, 16'h8000, 1'b0, 1'b0);
    // Neighbor lists, including a vertex with no outgoing edge
    send_request(OP_LIST, 8'h00, 8'h00, 16'h0000, 1'b0, 1'b0);
    send_request(OP_LIST, 8'hFF, 8'h00, 16'h0000, 1'b0, 1'b0);
    send_request(OP_LIST, 8'h80, 8'h00, 16'h0000, 1'b0, 1'b0);
    // Path through the loop, then a broken one
    send_request(OP_PATH, 8'h00, 8'h00, 16'h0000, 1'b1, 1'b0);
    send_request(OP_PATH, 8'hFF, 8'h00, 16'h0000, 1'b0, 1'b0);
    send_request(OP_PATH, 8'hFF, 8'h00, 16'h0000, 1'b0, 1'b0);
    send_request(OP_PATH, 8'h00, 8'h00, 16'h0000, 1'b0, 1'b1);
    send_request(OP_PATH, 8'h80, 8'h00, 16'h0000, 1'b1, 1'b0);
    send_request(OP_PATH, 8'h00, 8'h00, 16'h0000, 1'b0, 1'b1);
    send_request(OP_PATH, 8'h7F, 8'h00, 16'h0000, 1'b1, 1'b0);
    send_request(OP_PATH, 8'h01, 8'h00, 16'h0000, 1'b0, 1'b1);
    // Unused opcode
    send_request(OP_UNUSED, 8'h55, 8'hAA, 16'h5A5A, 1'b1, 1'b1);
    wait_results_drained();

    // Random mix of requests
    while (items_sent < ITEM_TARGET) begin
      quiet = (items_sent >= 130 && items_sent < 190);
      if (items_sent >= next_drain) begin
        wait_results_drained();
        next_drain += 70;
      end
      r = $urandom_range(99);
      if (r < 28) begin
        send_request(OP_ADD, pick_vertex(), pick_vertex(), WB'($urandom),
                     1'($urandom), 1'($urandom));
      end else if (r < 42) begin
        if (sb.n_edges > 0 && $urandom_range(99) < 70)
          send_request(OP_LIST, sb.src_tab[$urandom_range(sb.n_edges - 1)], VB'($urandom),
                       WB'($urandom), 1'($urandom), 1'($urandom));
        else
          send_request(OP_LIST, pick_vertex(), VB'($urandom), WB'($urandom),
                       1'($urandom), 1'($urandom));
      end else if (r < 88) begin
        send_path();
      end else if (r < 95) begin
        send_request(OP_PATH, pick_vertex(), VB'($urandom), WB'($urandom),
                     1'($urandom), 1'($urandom));
      end else begin
        send_request(OP_UNUSED, VB'($urandom), VB'($urandom), WB'($urandom),
                     1'($urandom), 1'($urandom));
      end
    end
    quiet = 1'b0;

    // Drain and let any trailing work settle
    wait_results_drained();
    repeat (200) @(posedge clk);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
